// ===== sv/madef_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types of the max-abs-difference edge filter
package madef_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;
	localparam int CFG_BITS       = 11;
	localparam int EDGE_BITS      = 8;
	localparam int WIDTH_RESET    = 1024;

	localparam logic ACT_DRAIN = 1'b1;

	// neighbour slots of the 3x3 window around the centre
	localparam int NB_COUNT = 8;
	localparam int NB_TL    = 0;
	localparam int NB_TC    = 1;
	localparam int NB_TR    = 2;
	localparam int NB_ML    = 3;
	localparam int NB_MR    = 4;
	localparam int NB_BL    = 5;
	localparam int NB_BC    = 6;
	localparam int NB_BR    = 7;

	typedef struct packed {
		logic                emit;
		logic                last;
		logic [NB_COUNT-1:0] mask;
	} madef_ctl_t;

endpackage

// ===== sv/madef_ram.sv =====
`timescale 1ns / 1ps
// generic ram with one write port and two registered read ports
module madef_ram #(
	parameter int WIDTH = madef_pkg::PIXEL_BITS_DEF,
	parameter int DEPTH = 2 ** $clog2(2 * madef_pkg::MAX_WIDTH_DEF + 3)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== sv/max_abs_diff_edge_filter.sv =====
`timescale 1ns / 1ps
// max-abs-difference 3x3 edge filter: top level
// pipeline: a result passes stage 1, stage 2 and the output register after its item is accepted
// throughput: one item per cycle, both pixels and drains, while pixel_stall is low
// a result window that does not continue the previous one (first drain after a short
//   image, first result after a width write or pending saturation) holds the item
//   while one or two columns are re-read from the history ram
// reset clears control state and sets width 1024 (or MAX_WIDTH if smaller); the history ram is not cleared
module max_abs_diff_edge_filter #(
	parameter int MAX_WIDTH  = madef_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = madef_pkg::PIXEL_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [madef_pkg::CFG_BITS-1:0]   image_width,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  logic                             action,
	input  logic [PIXEL_BITS-1:0]            pixel_value,
	input  logic                             start_of_image,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [madef_pkg::EDGE_BITS-1:0]  edge_value,
	output logic                             last_of_image
);
	import madef_pkg::*;

	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int PW         = $clog2(MAX_WIDTH + 2);
	localparam int HIST_DEPTH = 2 ** $clog2(2 * MAX_WIDTH + 3);
	localparam int AW         = $clog2(HIST_DEPTH);
	localparam int CMPW       = WW + 1;
	localparam int W_RST      = (WIDTH_RESET < MAX_WIDTH) ? WIDTH_RESET : MAX_WIDTH;

	// control state
	logic [WW-1:0] w_q;
	logic [PW-1:0] p_q;
	logic [CW-1:0] col_q;
	logic          first_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] xl_q;
	logic [1:0]    run_q;

	// last two written pixels
	logic [PIXEL_BITS-1:0] r1_q;
	logic [PIXEL_BITS-1:0] r2_q;

	// window columns: index 0 is two back, index 1 is one back
	logic [PIXEL_BITS-1:0] top_q [2];
	logic [PIXEL_BITS-1:0] mid_q [2];

	logic                  valid_s1;
	madef_ctl_t            ctl_s1;
	logic [PIXEL_BITS-1:0] bot_s1 [3];

	logic                  valid_s2;
	logic                  last_s2;
	logic [PIXEL_BITS-1:0] diff_s2 [NB_COUNT];

	logic                  res_v_q;
	logic [EDGE_BITS-1:0]  edge_q;
	logic                  last_q;

	// combinational
	logic                  is_drain;
	logic [PW-1:0]         w_p1;
	logic [PW-1:0]         p_sat;
	logic [PW-1:0]         p_new;
	logic                  emit_i;
	logic                  push_i;
	logic                  last_i;
	logic [AW-1:0]         col_x;
	logic [AW-1:0]         col_c;
	logic                  win_ok;
	logic                  near;
	logic                  reload;
	logic                  left_ok;
	logic                  right_ok;
	logic                  top_ok;
	logic                  down_ok;
	logic [NB_COUNT-1:0]   mask_i;
	madef_ctl_t            ctl_i;
	logic [AW-1:0]         addr_top;
	logic [AW-1:0]         addr_mid;
	logic [AW-1:0]         w2;
	logic [WW-1:0]         w_new;

	logic                  out_free;
	logic                  s2_free;
	logic                  s1_go;
	logic                  s1_free;
	logic                  issue;
	logic                  accept;
	logic                  push;
	logic                  cfg_we;
	logic                  hist_we;

	logic [PIXEL_BITS-1:0] ram_top;
	logic [PIXEL_BITS-1:0] ram_mid;
	logic [PIXEL_BITS-1:0] nb   [NB_COUNT];
	logic [PIXEL_BITS-1:0] diff [NB_COUNT];
	logic [PIXEL_BITS-1:0] best;

	// issue side
	always_comb begin
		is_drain = (action == ACT_DRAIN);
		w_p1     = PW'(w_q) + PW'(1);
		p_sat    = (p_q > w_p1) ? w_p1 : p_q;
		p_new    = start_of_image ? '0 : p_sat;
		emit_i   = is_drain ? (p_sat != '0) : (p_new == w_p1);
		push_i   = is_drain ? (p_sat != '0) : 1'b1;
		last_i   = is_drain && (p_sat == PW'(1));
		col_x    = is_drain ? (wp_q - AW'(p_sat) + AW'(w_q) + AW'(1)) : wp_q;
		win_ok   = (run_q == 2'd2) && (xl_q == col_x - AW'(1));
		near     = (run_q != 2'd0) && (xl_q == col_x - AW'(2));
		reload   = emit_i && !win_ok;
		if (reload) begin
			col_c = near ? (col_x - AW'(1)) : (col_x - AW'(2));
		end else begin
			col_c = col_x;
		end
		w2       = AW'(w_q) << 1;
		addr_top = col_c - w2;
		addr_mid = col_c - AW'(w_q);

		left_ok  = (col_q != '0);
		right_ok = (CMPW'(col_q) + CMPW'(1)) < CMPW'(w_q);
		top_ok   = !first_q;
		down_ok  = is_drain ? (p_sat == w_p1) : 1'b1;

		mask_i         = '0;
		mask_i[NB_TL]  = top_ok && left_ok;
		mask_i[NB_TC]  = top_ok;
		mask_i[NB_TR]  = top_ok && right_ok;
		mask_i[NB_ML]  = left_ok;
		mask_i[NB_MR]  = right_ok && !last_i;
		mask_i[NB_BL]  = down_ok && left_ok;
		mask_i[NB_BC]  = down_ok;
		mask_i[NB_BR]  = down_ok && right_ok && !is_drain;

		ctl_i.emit = emit_i && !reload;
		ctl_i.last = last_i;
		ctl_i.mask = mask_i;

		if (image_width == '0) begin
			w_new = WW'(1);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(image_width);
		end
	end

	// handshakes
	always_comb begin
		out_free    = !res_v_q || !result_stall;
		s2_free     = !valid_s2 || out_free;
		s1_go       = valid_s1 && (!ctl_s1.emit || s2_free);
		s1_free     = !valid_s1 || s1_go;
		issue       = pixel_valid && s1_free;
		accept      = issue && !reload;
		push        = issue && (reload || push_i);
		hist_we     = accept && !is_drain;
		pixel_stall = !s1_free || reload;
		cfg_ready   = 1'b1;
		cfg_we      = cfg_valid && cfg_ready;
	end

	madef_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk       (clk),
		.wr_en     (hist_we),
		.wr_addr   (wp_q),
		.wr_data   (pixel_value),
		.rd_en     (push),
		.rd_addr_a (addr_top),
		.rd_addr_b (addr_mid),
		.rd_data_a (ram_top),
		.rd_data_b (ram_mid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= WW'(W_RST);
			p_q     <= '0;
			col_q   <= '0;
			first_q <= 1'b1;
			wp_q    <= '0;
			xl_q    <= '0;
			run_q   <= 2'd0;
		end else begin
			if (push) begin
				xl_q <= col_c;
				if (run_q != 2'd0 && xl_q + AW'(1) == col_c) begin
					run_q <= (run_q == 2'd2) ? 2'd2 : run_q + 2'd1;
				end else begin
					run_q <= 2'd1;
				end
			end
			if (accept) begin
				if (!is_drain) begin
					wp_q <= wp_q + AW'(1);
					if (start_of_image) begin
						p_q     <= PW'(1);
						col_q   <= '0;
						first_q <= 1'b1;
					end else if (emit_i) begin
						p_q   <= p_sat;
						col_q <= right_ok ? col_q + CW'(1) : '0;
						if (!right_ok) begin
							first_q <= 1'b0;
						end
					end else begin
						p_q <= p_sat + PW'(1);
					end
				end else if (emit_i) begin
					p_q   <= p_sat - PW'(1);
					col_q <= right_ok ? col_q + CW'(1) : '0;
					if (!right_ok) begin
						first_q <= 1'b0;
					end
				end
			end
			if (cfg_we) begin
				w_q   <= w_new;
				run_q <= 2'd0;
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= push;
			end
			if (s2_free) begin
				valid_s2 <= s1_go && ctl_s1.emit;
			end
			if (out_free) begin
				res_v_q <= valid_s2;
			end
		end
	end

	// stage 1: window and absolute differences
	always_comb begin
		nb[NB_TL] = top_q[0];
		nb[NB_TC] = top_q[1];
		nb[NB_TR] = ram_top;
		nb[NB_ML] = mid_q[0];
		nb[NB_MR] = ram_mid;
		nb[NB_BL] = bot_s1[0];
		nb[NB_BC] = bot_s1[1];
		nb[NB_BR] = bot_s1[2];
		for (int i = 0; i < NB_COUNT; i++) begin
			if (!ctl_s1.mask[i]) begin
				diff[i] = '0;
			end else if (nb[i] > mid_q[1]) begin
				diff[i] = nb[i] - mid_q[1];
			end else begin
				diff[i] = mid_q[1] - nb[i];
			end
		end
	end

	// stage 2: largest difference
	always_comb begin
		best = '0;
		for (int i = 0; i < NB_COUNT; i++) begin
			if (diff_s2[i] > best) begin
				best = diff_s2[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			r2_q <= r1_q;
			r1_q <= pixel_value;
		end
		if (push) begin
			ctl_s1    <= ctl_i;
			bot_s1[0] <= r2_q;
			bot_s1[1] <= r1_q;
			bot_s1[2] <= pixel_value;
		end
		if (s1_go) begin
			top_q[0] <= top_q[1];
			top_q[1] <= ram_top;
			mid_q[0] <= mid_q[1];
			mid_q[1] <= ram_mid;
		end
		if (s1_go && ctl_s1.emit) begin
			diff_s2 <= diff;
			last_s2 <= ctl_s1.last;
		end
		if (out_free && valid_s2) begin
			edge_q <= EDGE_BITS'(best);
			last_q <= last_s2;
		end
	end

	assign result_valid  = res_v_q;
	assign edge_value    = edge_q;
	assign last_of_image = last_q;

endmodule
